[rtl/core/srtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths, controller states and the command and status words that
// pass between the scheduler controller and its datapath.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int MAX_PROCESSES_DEF = 16;

   localparam int ARR_W  = 16;   // arrival time
   localparam int BUR_W  = 12;   // burst and remaining time
   localparam int TIME_W = 17;   // current and completion time
   localparam int TA_W   = 16;   // turnaround and waiting time
   localparam int SUM_W  = 20;   // running sums
   localparam int PIDX_W = 4;    // reported process index

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 96;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN_START,
      ST_SCAN,
      ST_APPLY,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic apply;
      logic emit_start;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic start_sim;
      logic all_done;
      logic scan_done;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

[rtl/core/srtf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer for load, scan, apply and result phases of the scheduler.
// ----------------------------------------------------------------------------
module srtf_ctrl
   import srtf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.start_sim) begin
                  state_in = ST_SCAN_START;
               end
            end
         end
         ST_SCAN_START: begin
            if (status.all_done) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_RD;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_SCAN_START;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[rtl/core/srtf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_dp
// Process stores, scan for the shortest ready job and the next arrival,
// run-length update of time, and result arithmetic with output register.
// ----------------------------------------------------------------------------
module srtf_dp
   import srtf_pkg::*;
#(
   parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_PROCESSES - 1);

   // process stores
   logic [ARR_W-1:0]  arr_mem [MAX_PROCESSES];
   logic [BUR_W-1:0]  bur_mem [MAX_PROCESSES];
   logic [BUR_W-1:0]  rem_mem [MAX_PROCESSES];
   logic [TIME_W-1:0] fin_mem [MAX_PROCESSES];

   logic [ARR_W-1:0]  arr_rd_ff;
   logic [BUR_W-1:0]  bur_rd_ff;
   logic [BUR_W-1:0]  rem_rd_ff;
   logic [TIME_W-1:0] fin_rd_ff;

   // control state
   logic [CW-1:0]     loaded_ff, loaded_in;
   logic [CW-1:0]     done_ff, done_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SUM_W-1:0]  wsum_ff, wsum_in;
   logic [SUM_W-1:0]  tsum_ff, tsum_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic [BUR_W-1:0]  least_ff, least_in;
   logic [AW-1:0]     pick_ff, pick_in;
   logic              any_ff, any_in;
   logic [TIME_W-1:0] nxt_ff, nxt_in;
   logic              out_vld_ff, out_vld_in;

   // output word
   logic [PIDX_W-1:0] out_pidx_ff;
   logic [TIME_W-1:0] out_comp_ff;
   logic [TA_W-1:0]   out_ta_ff;
   logic [TA_W-1:0]   out_wt_ff;
   logic [SUM_W-1:0]  out_tw_ff;
   logic [SUM_W-1:0]  out_tt_ff;
   logic              out_last_ff;

   logic [ARR_W-1:0]  ld_arr;
   logic [BUR_W-1:0]  ld_bur;
   logic [TIME_W-1:0] rd_arr_ext;
   logic              rd_ready;
   logic              take_pick;
   logic              take_next;
   logic [TIME_W-1:0] gap;
   logic [BUR_W-1:0]  chunk;
   logic [BUR_W-1:0]  rem_new;
   logic              fin_now;
   logic [TIME_W-1:0] run_end;
   logic [TA_W-1:0]   ta;
   logic [TA_W-1:0]   wt;
   logic [SUM_W-1:0]  wsum_new;
   logic [SUM_W-1:0]  tsum_new;
   logic [CW-1:0]     idx_nx;

   assign ld_arr = req_tdata[ARR_W-1:0];
   assign ld_bur = (req_tdata[ARR_W+BUR_W-1:ARR_W] == '0) ? BUR_W'(1)
                                                          : req_tdata[ARR_W+BUR_W-1:ARR_W];

   // scan evaluation on registered read data
   assign rd_arr_ext = TIME_W'(arr_rd_ff);
   assign rd_ready   = (rd_arr_ext <= time_ff) && (rem_rd_ff != '0);
   assign take_pick  = rd_vld_ff && rd_ready && (!found_ff || (rem_rd_ff < least_ff));
   assign take_next  = rd_vld_ff && (rem_rd_ff != '0) && (rd_arr_ext > time_ff) &&
                       (!any_ff || (rd_arr_ext < nxt_ff));

   // chosen job runs until it ends or the next arrival
   assign gap     = nxt_ff - time_ff;
   assign chunk   = (any_ff && (gap < TIME_W'(least_ff))) ? BUR_W'(gap) : least_ff;
   assign rem_new = least_ff - chunk;
   assign fin_now = found_ff && (rem_new == '0);
   assign run_end = time_ff + TIME_W'(chunk);

   // result arithmetic
   assign ta       = TA_W'(fin_rd_ff) - arr_rd_ff;
   assign wt       = ta - TA_W'(bur_rd_ff);
   assign wsum_new = wsum_ff + SUM_W'(wt);
   assign tsum_new = tsum_ff + SUM_W'(ta);
   assign idx_nx   = idx_ff + CW'(1);

   always_comb begin
      status.start_sim = req_tlast || (loaded_ff == LAST_SLOT);
      status.all_done  = (done_ff == loaded_ff);
      status.scan_done = (idx_ff == loaded_ff) && !rd_vld_ff;
      status.out_free  = !out_vld_ff || rsp_tready;
      status.emit_last = (idx_nx == loaded_ff);
   end

   always_comb begin
      loaded_in  = loaded_ff;
      done_in    = done_ff;
      time_in    = time_ff;
      wsum_in    = wsum_ff;
      tsum_in    = tsum_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = rd_idx_ff;
      found_in   = found_ff;
      least_in   = least_ff;
      pick_in    = pick_ff;
      any_in     = any_ff;
      nxt_in     = nxt_ff;
      out_vld_in = out_vld_ff && !rsp_tready;

      if (cmd.load) begin
         loaded_in = loaded_ff + CW'(1);
      end

      if (cmd.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
         any_in   = 1'b0;
      end

      if (cmd.scan_step && (idx_ff < loaded_ff)) begin
         rd_vld_in = 1'b1;
         rd_idx_in = idx_ff[AW-1:0];
         idx_in    = idx_nx;
      end

      if (take_pick) begin
         found_in = 1'b1;
         least_in = rem_rd_ff;
         pick_in  = rd_idx_ff;
      end

      if (take_next) begin
         any_in = 1'b1;
         nxt_in = rd_arr_ext;
      end

      if (cmd.apply) begin
         if (found_ff) begin
            time_in = run_end;
            if (fin_now) begin
               done_in = done_ff + CW'(1);
            end
         end else begin
            time_in = any_ff ? nxt_ff : time_ff + TIME_W'(1);
         end
      end

      if (cmd.emit_start) begin
         idx_in = '0;
      end

      if (cmd.emit_load) begin
         out_vld_in = 1'b1;
         idx_in     = idx_nx;
         wsum_in    = wsum_new;
         tsum_in    = tsum_new;
         if (status.emit_last) begin
            loaded_in = '0;
            done_in   = '0;
            time_in   = '0;
            wsum_in   = '0;
            tsum_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= '0;
         done_ff    <= '0;
         time_ff    <= '0;
         wsum_ff    <= '0;
         tsum_ff    <= '0;
         idx_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         found_ff   <= 1'b0;
         any_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         loaded_ff  <= loaded_in;
         done_ff    <= done_in;
         time_ff    <= time_in;
         wsum_ff    <= wsum_in;
         tsum_ff    <= tsum_in;
         idx_ff     <= idx_in;
         rd_vld_ff  <= rd_vld_in;
         found_ff   <= found_in;
         any_ff     <= any_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      least_ff  <= least_in;
      pick_ff   <= pick_in;
      nxt_ff    <= nxt_in;
   end

   // store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arr_mem[loaded_ff[AW-1:0]] <= ld_arr;
         bur_mem[loaded_ff[AW-1:0]] <= ld_bur;
      end
      arr_rd_ff <= arr_mem[idx_ff[AW-1:0]];
      bur_rd_ff <= bur_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_mem[loaded_ff[AW-1:0]] <= ld_bur;
      end else if (cmd.apply && found_ff) begin
         rem_mem[pick_ff] <= rem_new;
      end
      rem_rd_ff <= rem_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.apply && fin_now) begin
         fin_mem[pick_ff] <= run_end;
      end
      fin_rd_ff <= fin_mem[idx_ff[AW-1:0]];
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_pidx_ff <= PIDX_W'(idx_ff);
         out_comp_ff <= fin_rd_ff;
         out_ta_ff   <= ta;
         out_wt_ff   <= wt;
         out_tw_ff   <= status.emit_last ? wsum_new : '0;
         out_tt_ff   <= status.emit_last ? tsum_new : '0;
         out_last_ff <= status.emit_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_tt_ff, out_tw_ff, out_wt_ff, out_ta_ff,
                        out_comp_ff, out_pidx_ff};

endmodule

[rtl/core/srtf_schedule_simulator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_schedule_simulator_unit
// Preemptive shortest-remaining-time-first schedule simulator.
// ----------------------------------------------------------------------------
// Usage:
//   Each req word loads one process (arrival, burst). A word with tlast, or
//   the word that fills all MAX_PROCESSES slots, starts the simulation.
//   Loading takes one cycle per word; req_tready is low while the set runs.
//   The schedule is simulated event by event: each event is a start state,
//   a scan of all n loaded processes and an apply state, and runs the
//   chosen process up to its completion or the next arrival. A set needs
//   at most 2n events before the first result. Results follow in load
//   order, one per process, each read from the stores and then loaded into
//   the output register; rsp_tlast and the totals mark the final one. The
//   output register holds each rsp word while rsp_tready is low; the
//   sequencer waits on it and the next set may load meanwhile.
//   Reset clears the set, the counters and the output valid; stores need
//   no clearing.
// ----------------------------------------------------------------------------
module srtf_schedule_simulator_unit
   import srtf_pkg::*;
#(
   parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // arrival_time, burst_time
   input  logic                  req_tlast,   // last_process
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // process_index, completion_time, turnaround_time, waiting_time,
   // total_waiting, total_turnaround
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast    // last_result
);

   cmd_type    cmd;
   status_type status;

   srtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srtf_dp #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_apply_after_scan : assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $past(status.scan_done))
      else $error("apply without finished scan");

   a_emit_room : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free)
      else $error("result word overwritten");

   a_back_to_load : assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load && status.emit_last |=> req_tready)
      else $error("no return to load after final result");

   a_start_blocks_load : assert property (@(posedge clock) disable iff (reset)
      cmd.load && status.start_sim |=> !req_tready)
      else $error("load taken while set runs");
`endif

endmodule
